[rtl/core/gvafa_pkg.sv]
`timescale 1ns / 1ps

package gvafa_pkg;

  // Table and field geometry.
  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BITS   = 36;
  localparam int ALIGN_BITS  = 31;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  // A region may start one page past the address space, so starts carry one extra bit.
  localparam int START_W     = PAGE_BITS + 1;
  // Region ends and overflow sums need two extra bits.
  localparam int SUM_W       = PAGE_BITS + 2;

  localparam logic [ALIGN_BITS-1:0] ALIGN_GAP_LIMIT = ALIGN_BITS'(4096);
  localparam logic [SUM_W-1:0]      PAGE_LIMIT      = SUM_W'(1) << PAGE_BITS;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e_t;

  typedef struct packed {
    op_e_t                 operation;
    logic [PAGE_BITS-1:0]  size_pages;
    logic [ALIGN_BITS-1:0] alignment;
    logic [PAGE_BITS-1:0]  address_page;
  } req_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] placed_page;
    status_e_t            status;
  } rsp_t;

  typedef struct packed {
    logic [START_W-1:0]   start;
    logic [PAGE_BITS-1:0] length;
  } entry_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_WALK_RD,
    CS_WALK_EV,
    CS_SHUP_RD,
    CS_SHUP_WR,
    CS_SHDN_RD,
    CS_SHDN_WR,
    CS_APPEND_PREP,
    CS_APPEND_CHK,
    CS_WRITE_NEW,
    CS_RESULT
  } ctl_state_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      walk_rd;
    logic      walk_ev;
    logic      shup_rd;
    logic      shup_wr;
    logic      shdn_rd;
    logic      shdn_wr;
    logic      append_prep;
    logic      write_new;
    logic      cnt_dec;
    logic      res_load;
    logic      res_page;
    status_e_t res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic walk_last;
    logic up_done;
    logic down_done;
    logic overflow;
    logic is_free;
    logic out_ready;
  } dp_sts_t;

endpackage

[rtl/core/gpu_va_first_fit_allocator.sv]
`timescale 1ns / 1ps
// Channel  Ports                              Payload
// in       in_valid, in_stall, in_req         req_t: operation, size, alignment, page
// out      out_valid, out_stall, out_rsp      rsp_t: placed_page, status
// cfg      cfg_wr_en, cfg_wr_data             reserved_pages
//
// One request is handled at a time. The walk over the region table visits one region
// at a time (memory read, then compare), and an insert or removal moves the regions
// above it one at a time, each with a read and then a write. Reset is synchronous and
// empties the table with no clearing pass. A finished result waits in the output register
// while out_stall is high, and the next request is taken meanwhile.

module gpu_va_first_fit_allocator import gvafa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  req_t                 in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_rsp,
  input  logic                 cfg_wr_en,
  input  logic [PAGE_BITS-1:0] cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  gvafa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_req.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Region table, walk arithmetic and output register.
  gvafa_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp)
  );

endmodule

[rtl/core/gvafa_datapath.sv]
`timescale 1ns / 1ps

module gvafa_datapath import gvafa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  req_t                 in_req,
  input  logic                 cfg_wr_en,
  input  logic [PAGE_BITS-1:0] cfg_wr_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_rsp
);

  // Region table: one write port, one registered read port.
  entry_t mem [MAX_REGIONS];
  entry_t rdata_r;

  logic [PAGE_BITS-1:0] reserved_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     idx_r;
  logic [IDX_W-1:0]     ptr_r;
  logic [SUM_W-1:0]     prev_end_r;

  op_e_t                op_r;
  logic [PAGE_BITS-1:0] size_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 align_ok_r;

  logic                 out_valid_r;
  rsp_t                 out_rsp_r;

  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic                 wr_en;

  logic [SUM_W-1:0]     next_w;
  logic [SUM_W-1:0]     size_w;
  logic [SUM_W-1:0]     entry_end;
  logic                 gap_fit;
  logic                 page_match;

  // Widened operands for the walk compare.
  assign next_w     = SUM_W'(rdata_r.start);
  assign size_w     = SUM_W'(size_r);
  assign entry_end  = SUM_W'(rdata_r.start) + SUM_W'(rdata_r.length);
  assign gap_fit    = align_ok_r && (next_w > prev_end_r) && ((next_w - prev_end_r) > size_w);
  assign page_match = (rdata_r.start == START_W'(page_r));

  // Memory address and write selection.
  always_comb begin
    rd_addr = ptr_r;
    if (cmd.walk_rd) begin
      rd_addr = idx_r[IDX_W-1:0];
    end
    wr_en   = cmd.shup_wr || cmd.shdn_wr || cmd.write_new;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = rdata_r;
    if (cmd.shup_wr) begin
      wr_addr = ptr_r + 1'b1;
    end else if (cmd.shdn_wr) begin
      wr_addr = ptr_r - 1'b1;
    end else begin
      wr_data.start  = prev_end_r[START_W-1:0];
      wr_data.length = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Request capture, walk pointers and table fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= PAGE_BITS'(1);
      count_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        reserved_r <= cfg_wr_data;
      end
      if (cmd.write_new) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_req.operation;
      size_r     <= in_req.size_pages;
      page_r     <= in_req.address_page;
      align_ok_r <= (in_req.alignment <= ALIGN_GAP_LIMIT);
      idx_r      <= '0;
      prev_end_r <= SUM_W'(reserved_r);
    end else if (cmd.walk_ev) begin
      if (sts.hit) begin
        // Start of the shift: from the top for an insert, above the hit for a removal.
        if (op_r == OP_FREE) begin
          ptr_r <= idx_r[IDX_W-1:0] + 1'b1;
        end else begin
          ptr_r <= IDX_W'(count_r - 1'b1);
        end
      end else begin
        prev_end_r <= entry_end;
        idx_r      <= idx_r + 1'b1;
      end
    end else if (cmd.append_prep) begin
      prev_end_r <= prev_end_r + 1'b1;
    end else if (cmd.shup_wr) begin
      ptr_r <= ptr_r - 1'b1;
    end else if (cmd.shdn_wr) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_rsp_r.placed_page <= cmd.res_page ? prev_end_r[PAGE_BITS-1:0] : '0;
      out_rsp_r.status      <= cmd.res_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Status back to the controller.
  always_comb begin
    sts.full      = (count_r == CNT_W'(MAX_REGIONS));
    sts.empty     = (count_r == '0);
    sts.is_free   = (op_r == OP_FREE);
    sts.hit       = (op_r == OP_FREE) ? page_match : gap_fit;
    sts.walk_last = ((idx_r + 1'b1) == count_r);
    sts.up_done   = (ptr_r == idx_r[IDX_W-1:0]);
    sts.down_done = ((CNT_W'(ptr_r) + 1'b1) == count_r);
    sts.overflow  = ((prev_end_r + size_w) > PAGE_LIMIT);
    sts.out_ready = !out_valid_r || !out_stall;
  end

endmodule

[rtl/core/gvafa_ctrl.sv]
`timescale 1ns / 1ps

module gvafa_ctrl import gvafa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  op_e_t   in_op,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_e_t state_r, state_nxt;
  status_e_t    code_r, code_nxt;
  logic         page_r, page_nxt;

  // State and pending result code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      code_r  <= ST_OK;
      page_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      page_r  <= page_nxt;
    end
  end

  assign in_stall = (state_r != CS_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    page_nxt       = page_r;
    cmd            = '0;
    cmd.res_status = code_r;
    cmd.res_page   = page_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          page_nxt = 1'b0;
          if (in_op == OP_FREE) begin
            if (sts.empty) begin
              code_nxt  = ST_UNKNOWN;
              state_nxt = CS_RESULT;
            end else begin
              state_nxt = CS_WALK_RD;
            end
          end else if (sts.full) begin
            code_nxt  = ST_FULL;
            state_nxt = CS_RESULT;
          end else if (sts.empty) begin
            state_nxt = CS_APPEND_PREP;
          end else begin
            state_nxt = CS_WALK_RD;
          end
        end
      end
      CS_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = CS_WALK_EV;
      end
      CS_WALK_EV: begin
        cmd.walk_ev = 1'b1;
        if (sts.hit) begin
          if (!sts.is_free) begin
            state_nxt = CS_SHUP_RD;
          end else if (sts.walk_last) begin
            // Removing the last region needs no shift.
            cmd.cnt_dec = 1'b1;
            code_nxt    = ST_OK;
            state_nxt   = CS_RESULT;
          end else begin
            state_nxt = CS_SHDN_RD;
          end
        end else if (sts.walk_last) begin
          if (sts.is_free) begin
            code_nxt  = ST_UNKNOWN;
            state_nxt = CS_RESULT;
          end else begin
            state_nxt = CS_APPEND_PREP;
          end
        end else begin
          state_nxt = CS_WALK_RD;
        end
      end
      CS_SHUP_RD: begin
        cmd.shup_rd = 1'b1;
        state_nxt   = CS_SHUP_WR;
      end
      CS_SHUP_WR: begin
        cmd.shup_wr = 1'b1;
        state_nxt   = sts.up_done ? CS_WRITE_NEW : CS_SHUP_RD;
      end
      CS_SHDN_RD: begin
        cmd.shdn_rd = 1'b1;
        state_nxt   = CS_SHDN_WR;
      end
      CS_SHDN_WR: begin
        cmd.shdn_wr = 1'b1;
        if (sts.down_done) begin
          cmd.cnt_dec = 1'b1;
          code_nxt    = ST_OK;
          state_nxt   = CS_RESULT;
        end else begin
          state_nxt = CS_SHDN_RD;
        end
      end
      CS_APPEND_PREP: begin
        // Leave the one-page guard gap.
        cmd.append_prep = 1'b1;
        state_nxt       = CS_APPEND_CHK;
      end
      CS_APPEND_CHK: begin
        if (sts.overflow) begin
          code_nxt  = ST_OVERFLOW;
          state_nxt = CS_RESULT;
        end else begin
          state_nxt = CS_WRITE_NEW;
        end
      end
      CS_WRITE_NEW: begin
        cmd.write_new = 1'b1;
        code_nxt      = ST_OK;
        page_nxt      = 1'b1;
        state_nxt     = CS_RESULT;
      end
      CS_RESULT: begin
        if (sts.out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/gvafa_checker.sv]
`timescale 1ns / 1ps

module gvafa_checker import gvafa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rsp_t out_rsp
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // Every failed request reports page zero.
  a_err_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_OK) |-> (out_rsp.placed_page == '0))
    else $error("error result with nonzero page");

  // Only one request is in flight: an accepted request stalls the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind gpu_va_first_fit_allocator gvafa_checker u_gvafa_checker (.*);
